// ===== rtl/bsc_pkg.sv =====
// Package for the banker's safety check engine.
// Shared constants, command and status codes. No dependencies.
`default_nettype none
package bsc_pkg;
  localparam int unsigned ProcsDefault = 16;
  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned WorkW = 20;
  localparam int unsigned ActW = 5;

  localparam logic [1:0] CmdLoad    = 2'd0;
  localparam logic [1:0] CmdTotals  = 2'd1;
  localparam logic [1:0] CmdCheck   = 2'd2;
  localparam logic [1:0] CmdRequest = 2'd3;

  localparam logic [2:0] StDone     = 3'd0;
  localparam logic [2:0] StFinished = 3'd1;
  localparam logic [2:0] StSafe     = 3'd2;
  localparam logic [2:0] StNeed     = 3'd3;
  localparam logic [2:0] StAvail    = 3'd4;
  localparam logic [2:0] StUnsafe   = 3'd5;
  localparam logic [2:0] StBadRow   = 3'd6;
  localparam logic [2:0] StOver     = 3'd7;
endpackage
`default_nettype wire

// ===== rtl/bankers_safety_check_core.sv =====
// Banker's algorithm engine for three resource types, top level.
// Uses bsc_pkg. Allocation and need rows live in one synchronous memory.
//
// Each item is handled one at a time. A load is handled in the S_LD state;
// set totals walks the allocation memory, one row per cycle. A check or
// request scans the rows in passes through the single read port of the row
// memory: each row visit is a read state, then a test state (S_CHKRD, then
// S_CHK), and each finished row waits in S_OUT until the output is free. After
// reset the row memory is cleared row by row, and no item is accepted
// until the clear is done.
`default_nettype none
module bankers_safety_check_core #(
  parameter int unsigned PROCS = bsc_pkg::ProcsDefault,
  parameter int unsigned COUNT_WIDTH = bsc_pkg::CountWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,     // [4:0] active_processes
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [1:0] command, [5:2] process_index, [21:6] amount_a, [37:22] amount_b,
  // [53:38] amount_c, [69:54] max_a, [85:70] max_b, [101:86] max_c
  input  wire logic [103:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [2:0] status, [6:3] finished_process, [26:7] work_a, [46:27] work_b,
  // [66:47] work_c
  output logic [71:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);
  localparam int unsigned IW = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int unsigned CW = (PROCS > 1) ? $clog2(PROCS + 1) : 1;
  localparam int unsigned CNTW = COUNT_WIDTH;
  localparam int unsigned SW = CNTW + $clog2(PROCS + 1);
  localparam int unsigned WW = SW + 1;
  localparam int unsigned RW = 6 * CNTW;
  localparam int unsigned ActW_l = bsc_pkg::ActW;

  // state codes
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_LD = 4'd2, S_SUMRD = 4'd3,
    S_SUM = 4'd4, S_REQRD = 4'd5, S_REQ = 4'd6, S_CHKRD = 4'd7, S_CHK = 4'd8,
    S_OUT = 4'd9, S_UNDO = 4'd10, S_UNDOWR = 4'd11, S_VERD = 4'd12;

  logic [3:0] st_q, st_d;
  logic [RW-1:0] mem [PROCS];
  logic [RW-1:0] rd_q;
  logic rd_en;
  logic [IW-1:0] rd_addr;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  logic [RW-1:0] wr_data;

  logic [ActW_l-1:0] act_q;
  logic [1:0] cmd_q;
  logic [3:0] pidx_q;
  logic [CNTW-1:0] amt_q [3];
  logic [CNTW-1:0] mx_q [3];
  logic [CNTW-1:0] avail_q [3];
  logic [SW-1:0] sum_q [3];
  logic [WW-1:0] work_q [3];
  logic [PROCS-1:0] fin_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] done_q;
  logic prog_q;
  logic [CW-1:0] n_c;
  logic req_ok_q;
  logic [2:0] req_st_q;

  logic [2:0] o_st_q;
  logic [3:0] o_proc_q;
  logic [bsc_pkg::WorkW-1:0] o_w_q [3];
  logic o_last_q;
  logic o_valid_q;

  logic [CNTW-1:0] ra [3], rn [3], in_amt [3], in_mx [3];
  for (genvar j = 0; j < 3; j++) begin : g_f
    assign ra[j] = rd_q[j*CNTW +: CNTW];
    assign rn[j] = rd_q[(3+j)*CNTW +: CNTW];
    assign in_amt[j] = CNTW'(s_axis_tdata_i[6 + 16*j +: 16]);
    assign in_mx[j] = CNTW'(s_axis_tdata_i[54 + 16*j +: 16]);
  end

  assign n_c = (32'(act_q) > PROCS) ? CW'(PROCS) : CW'(act_q);
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready_o = (st_q == S_IDLE) && !o_valid_q;
  wire in_acc = s_axis_tvalid_i && s_axis_tready_o;
  wire out_free = !o_valid_q || m_axis_tready_i;

  // row memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // per-row test terms
  logic fits, bad_ld, need_fail [3], av_fail [3];
  always_comb begin
    fits = 1'b1;
    bad_ld = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (work_q[j] < WW'(rn[j])) fits = 1'b0;
      if (mx_q[j] < amt_q[j]) bad_ld = 1'b1;
      need_fail[j] = amt_q[j] > rn[j];
      av_fail[j] = amt_q[j] > avail_q[j];
    end
  end
  logic [2:0] req_st;
  logic req_ok;
  always_comb begin
    req_st = bsc_pkg::StDone;
    req_ok = 1'b1;
    for (int j = 2; j >= 0; j--) begin
      if (av_fail[j]) begin req_st = bsc_pkg::StAvail; req_ok = 1'b0; end
      if (need_fail[j]) begin req_st = bsc_pkg::StNeed; req_ok = 1'b0; end
    end
  end
  logic over;
  always_comb begin
    over = 1'b0;
    for (int j = 0; j < 3; j++) if (sum_q[j] > SW'(amt_q[j])) over = 1'b1;
  end
  wire last_idx = (CW'(idx_q) + CW'(1)) >= n_c;

  // control
  logic emit;
  logic [2:0] e_st;
  logic [3:0] e_proc;
  logic e_last, e_work;
  always_comb begin
    st_d = st_q;
    rd_en = 1'b0; rd_addr = idx_q;
    wr_en = 1'b0; wr_addr = idx_q; wr_data = '0;
    emit = 1'b0; e_st = bsc_pkg::StDone; e_proc = '0; e_last = 1'b1; e_work = 1'b0;
    unique case (st_q)
      S_CLR: begin
        wr_en = 1'b1;
        if (32'(idx_q) == PROCS - 1) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (s_axis_tdata_i[1:0])
            bsc_pkg::CmdLoad: st_d = S_LD;
            bsc_pkg::CmdTotals: st_d = S_SUMRD;
            bsc_pkg::CmdCheck: st_d = S_CHKRD;
            default: st_d = S_REQRD;
          endcase
        end
      end
      S_LD: if (out_free) begin
        emit = 1'b1;
        if (32'(pidx_q) >= PROCS || bad_ld) e_st = bsc_pkg::StBadRow;
        else begin
          wr_en = 1'b1; wr_addr = IW'(pidx_q);
          for (int j = 0; j < 3; j++) begin
            wr_data[j*CNTW +: CNTW] = amt_q[j];
            wr_data[(3+j)*CNTW +: CNTW] = mx_q[j] - amt_q[j];
          end
        end
        st_d = S_IDLE;
      end
      S_SUMRD: begin
        if (n_c == '0) st_d = S_VERD;
        else begin rd_en = 1'b1; st_d = S_SUM; end
      end
      S_SUM: begin
        if (last_idx) st_d = S_VERD;
        else begin rd_en = 1'b1; rd_addr = idx_q + IW'(1); end
      end
      S_REQRD: begin
        if (CW'(pidx_q) >= n_c || 32'(pidx_q) >= PROCS) st_d = S_VERD;
        else begin rd_en = 1'b1; rd_addr = IW'(pidx_q); st_d = S_REQ; end
      end
      S_REQ: begin
        if (!req_ok) st_d = S_VERD;
        else begin
          wr_en = 1'b1; wr_addr = IW'(pidx_q);
          for (int j = 0; j < 3; j++) begin
            wr_data[j*CNTW +: CNTW] = ra[j] + amt_q[j];
            wr_data[(3+j)*CNTW +: CNTW] = rn[j] - amt_q[j];
          end
          st_d = S_CHKRD;
        end
      end
      S_CHKRD: begin
        if (done_q >= n_c) st_d = S_VERD;
        else if (fin_q[idx_q]) begin
          if (last_idx && !prog_q) st_d = S_VERD;
        end else begin rd_en = 1'b1; st_d = S_CHK; end
      end
      S_CHK: begin
        if (fits) st_d = S_OUT;
        else if (last_idx && !prog_q) st_d = S_VERD;
        else st_d = S_CHKRD;
      end
      S_OUT: if (out_free) begin
        emit = 1'b1; e_st = bsc_pkg::StFinished; e_proc = 4'(idx_q);
        e_last = 1'b0; e_work = 1'b1;
        st_d = S_CHKRD;
      end
      S_VERD: if (out_free) begin
        emit = 1'b1; st_d = S_IDLE;
        unique case (cmd_q)
          bsc_pkg::CmdTotals: e_st = over ? bsc_pkg::StOver : bsc_pkg::StDone;
          bsc_pkg::CmdCheck: begin
            e_work = 1'b1;
            e_st = (done_q >= n_c) ? bsc_pkg::StSafe : bsc_pkg::StUnsafe;
          end
          default: begin
            if (CW'(pidx_q) >= n_c || 32'(pidx_q) >= PROCS) e_st = bsc_pkg::StNeed;
            else if (done_q >= n_c) begin e_st = bsc_pkg::StSafe; e_work = 1'b1; end
            else if (!req_ok_q) e_st = req_st_q;
            else begin
              e_st = bsc_pkg::StUnsafe; e_work = 1'b1;
              emit = 1'b0; rd_en = 1'b1; rd_addr = IW'(pidx_q); st_d = S_UNDO;
            end
          end
        endcase
      end
      S_UNDO: begin
        wr_en = 1'b1; wr_addr = IW'(pidx_q);
        for (int j = 0; j < 3; j++) begin
          wr_data[j*CNTW +: CNTW] = ra[j] - amt_q[j];
          wr_data[(3+j)*CNTW +: CNTW] = rn[j] + amt_q[j];
        end
        st_d = S_UNDOWR;
      end
      S_UNDOWR: if (out_free) begin
        emit = 1'b1; e_st = bsc_pkg::StUnsafe; e_work = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR;
      idx_q <= '0;
      act_q <= ActW_l'(16);
      o_valid_q <= 1'b0;
      done_q <= '0;
      prog_q <= 1'b0;
      fin_q <= '0;
      req_ok_q <= 1'b1;
      req_st_q <= bsc_pkg::StDone;
      cmd_q <= bsc_pkg::CmdLoad;
      pidx_q <= '0;
      for (int j = 0; j < 3; j++) begin
        avail_q[j] <= '0; sum_q[j] <= '0; work_q[j] <= '0;
        amt_q[j] <= '0; mx_q[j] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) act_q <= cfg_data_i[ActW_l-1:0];
      if (emit) o_valid_q <= 1'b1;
      else if (m_axis_tready_i) o_valid_q <= 1'b0;
      unique case (st_q)
        S_CLR: idx_q <= idx_q + IW'(1);
        S_IDLE: if (in_acc) begin
          idx_q <= '0; done_q <= '0; prog_q <= 1'b0; fin_q <= '0;
          req_ok_q <= 1'b1;
          cmd_q <= s_axis_tdata_i[1:0];
          pidx_q <= s_axis_tdata_i[5:2];
          for (int j = 0; j < 3; j++) begin
            amt_q[j] <= in_amt[j]; mx_q[j] <= in_mx[j];
            sum_q[j] <= (s_axis_tdata_i[1:0] == bsc_pkg::CmdTotals) ? '0 : sum_q[j];
            work_q[j] <= WW'(avail_q[j]);
          end
        end
        S_SUM: begin
          idx_q <= idx_q + IW'(1);
          for (int j = 0; j < 3; j++) sum_q[j] <= sum_q[j] + SW'(ra[j]);
        end
        S_REQ: begin
          req_ok_q <= req_ok; req_st_q <= req_st;
          if (req_ok) for (int j = 0; j < 3; j++) begin
            avail_q[j] <= avail_q[j] - amt_q[j];
            work_q[j] <= WW'(avail_q[j] - amt_q[j]);
          end
        end
        S_CHKRD: if (done_q < n_c && fin_q[idx_q]) begin
          idx_q <= last_idx ? '0 : idx_q + IW'(1);
          if (last_idx) prog_q <= 1'b0;
        end
        S_CHK: if (fits) begin
          fin_q[idx_q] <= 1'b1;
          done_q <= done_q + CW'(1);
          prog_q <= 1'b1;
          for (int j = 0; j < 3; j++) work_q[j] <= work_q[j] + WW'(ra[j]);
        end else begin
          idx_q <= last_idx ? '0 : idx_q + IW'(1);
          if (last_idx) prog_q <= 1'b0;
        end
        S_OUT: if (out_free) begin
          idx_q <= last_idx ? '0 : idx_q + IW'(1);
          if (last_idx) prog_q <= 1'b0;
        end
        S_VERD: if (out_free) begin
          if (cmd_q == bsc_pkg::CmdTotals && !over)
            for (int j = 0; j < 3; j++) avail_q[j] <= amt_q[j] - CNTW'(sum_q[j]);
          if (cmd_q == bsc_pkg::CmdRequest && req_ok_q && CW'(pidx_q) < n_c &&
              32'(pidx_q) < PROCS && done_q >= n_c)
            for (int j = 0; j < 3; j++) sum_q[j] <= sum_q[j] + SW'(amt_q[j]);
        end
        S_UNDO:
          for (int j = 0; j < 3; j++) avail_q[j] <= avail_q[j] + amt_q[j];
        default: ;
      endcase
    end
  end

  // output register, work already includes the finished row
  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_st_q <= e_st;
      o_proc_q <= e_proc;
      o_last_q <= e_last;
      for (int j = 0; j < 3; j++)
        o_w_q[j] <= e_work ? work_q[j][bsc_pkg::WorkW-1:0] : '0;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tlast_o = o_last_q;
  assign m_axis_tdata_o = {5'd0, o_w_q[2], o_w_q[1], o_w_q[0], o_proc_q, o_st_q};

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> st_q == S_IDLE) else $error("accept while busy");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("result overwritten");
  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= CW'(PROCS)) else $error("finish count overflow");
endmodule
`default_nettype wire
